/* rtl/assert_macros.svh */
// assertion macros used by the checker file cdl_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define CDL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true outside reset
`define CDL_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `CDL_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

/* rtl/cdl_pkg.sv */
// shared constants, codes and types of the circular list engine
// no dependencies
package cdl_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ReqW        = 3;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned StatusW     = 2;

  // request codes
  localparam logic [ReqW-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [ReqW-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [ReqW-1:0] REQ_DELETE    = 3'd2;
  localparam logic [ReqW-1:0] REQ_REVERSE   = 3'd3;
  localparam logic [ReqW-1:0] REQ_TRAVERSE  = 3'd4;

  // result status codes
  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL      = 2'd1;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [StatusW-1:0] STAT_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_LINK,
    ST_DEL_CHK,
    ST_REV_STEP,
    ST_TRV_OUT,
    ST_RESP
  } cdl_state_e;

endpackage

/* rtl/cdl_ifs.sv */
// request and response channel interfaces of the circular list engine
// depends on cdl_pkg
interface cdl_req_if;
  logic                               valid;
  logic                               ready;
  logic [cdl_pkg::ReqW-1:0]           req_type;
  logic signed [cdl_pkg::ValueW-1:0]  item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface cdl_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [cdl_pkg::ValueW-1:0]  out_value;
  logic [cdl_pkg::StatusW-1:0]        status;
  logic                               is_element;
  logic                               last;

  modport source (output valid, output out_value, output status, output is_element,
                  output last, input ready);
  modport sink   (input valid, input out_value, input status, input is_element,
                  input last, output ready);
endinterface

/* rtl/circular_double_list_engine.sv */
// top level of the circular doubly linked list engine
// depends on cdl_pkg and the channel interfaces in cdl_ifs.sv
//
// A bounded circular doubly linked list of signed 32-bit values kept in a pool of
// CAPACITY nodes. Each request transaction on req_i is one of: insert front, insert
// back, delete the first match from the head, reverse, traverse. A traverse returns
// every element head to tail (status ok, is_element set, last on the tail); an empty
// traverse returns one empty status. Every other request returns one status result
// with out_value zero. An insert into a full pool is dropped with status full, a
// delete without a match reports not_found, codes five to seven are answered ok.
// Node value, next link and prev link live in three single-port-read synchronous
// memories with registered read data; the free pool is a bitmap, the lowest free
// node is taken. Requests are handled one at a time. The walk over the list
// advances one node per memory read, the next link read feeding the next read
// address directly. A request may be taken while the previous result still waits
// in the output register.
module circular_double_list_engine #(
  parameter int unsigned CAPACITY = cdl_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdl_req_if.sink     req_i,
  cdl_rsp_if.source   rsp_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ValW = cdl_pkg::ValueW;

  // node pool memories
  logic signed [ValW-1:0] val_mem [CAPACITY];
  logic [IdxW-1:0]        nxt_mem [CAPACITY];
  logic [IdxW-1:0]        prv_mem [CAPACITY];

  logic signed [ValW-1:0] val_rdata_q;
  logic [IdxW-1:0]        nxt_rdata_q;
  logic [IdxW-1:0]        prv_rdata_q;

  logic                   rd_en;
  logic [IdxW-1:0]        rd_addr;
  logic                   val_we, nxt_we, prv_we;
  logic [IdxW-1:0]        val_waddr, nxt_waddr, prv_waddr;
  logic signed [ValW-1:0] val_wdata;
  logic [IdxW-1:0]        nxt_wdata, prv_wdata;

  // control state
  cdl_pkg::cdl_state_e    state_q, state_d;
  logic [CAPACITY-1:0]    used_q, used_d;
  logic [IdxW-1:0]        head_q, head_d;
  logic [IdxW-1:0]        tail_q, tail_d;
  logic [CntW-1:0]        count_q, count_d;

  // per-request working registers
  logic signed [ValW-1:0] value_q, value_d;
  logic                   at_front_q, at_front_d;
  logic [IdxW-1:0]        slot_q, slot_d;
  logic [IdxW-1:0]        cur_q, cur_d;
  logic [CntW-1:0]        k_q, k_d;
  logic [cdl_pkg::StatusW-1:0] status_q, status_d;

  // output register
  logic                        out_valid_q;
  logic signed [ValW-1:0]      out_value_q, out_value_d;
  logic [cdl_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic                        out_elem_q, out_elem_d;
  logic                        out_last_q, out_last_d;
  logic                        out_load;
  logic                        can_load;

  logic [IdxW-1:0]        free_slot;
  logic                   pool_full;
  logic                   walk_last;

  assign can_load  = !out_valid_q || rsp_o.ready;
  assign pool_full = &used_q;
  assign walk_last = (k_q + CntW'(1)) == count_q;

  // lowest free node
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) free_slot = IdxW'(i);
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    if (rd_en) val_rdata_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    if (rd_en) nxt_rdata_q <= nxt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) prv_mem[prv_waddr] <= prv_wdata;
    if (rd_en) prv_rdata_q <= prv_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    value_d      = value_q;
    at_front_d   = at_front_q;
    slot_d       = slot_q;
    cur_d        = cur_q;
    k_d          = k_q;
    status_d     = status_q;

    rd_en        = 1'b0;
    rd_addr      = cur_q;
    val_we       = 1'b0;
    val_waddr    = slot_q;
    val_wdata    = value_q;
    nxt_we       = 1'b0;
    nxt_waddr    = slot_q;
    nxt_wdata    = slot_q;
    prv_we       = 1'b0;
    prv_waddr    = slot_q;
    prv_wdata    = slot_q;

    out_load     = 1'b0;
    out_value_d  = '0;
    out_status_d = status_q;
    out_elem_d   = 1'b0;
    out_last_d   = 1'b1;

    req_i.ready  = 1'b0;

    unique case (state_q)
      cdl_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          value_d = req_i.item_value;
          k_d     = '0;
          cur_d   = head_q;
          unique case (req_i.req_type)
            cdl_pkg::REQ_INS_FRONT, cdl_pkg::REQ_INS_BACK: begin
              at_front_d = (req_i.req_type == cdl_pkg::REQ_INS_FRONT);
              if (pool_full) begin
                status_d = cdl_pkg::STAT_FULL;
                state_d  = cdl_pkg::ST_RESP;
              end else begin
                // write the new node; its links close on itself when the list is empty
                slot_d    = free_slot;
                val_we    = 1'b1;
                val_waddr = free_slot;
                val_wdata = req_i.item_value;
                nxt_we    = 1'b1;
                nxt_waddr = free_slot;
                prv_we    = 1'b1;
                prv_waddr = free_slot;
                used_d[free_slot] = 1'b1;
                count_d   = count_q + CntW'(1);
                status_d  = cdl_pkg::STAT_OK;
                if (count_q == '0) begin
                  nxt_wdata = free_slot;
                  prv_wdata = free_slot;
                  head_d    = free_slot;
                  tail_d    = free_slot;
                  state_d   = cdl_pkg::ST_RESP;
                end else begin
                  nxt_wdata = head_q;
                  prv_wdata = tail_q;
                  state_d   = cdl_pkg::ST_INS_LINK;
                end
              end
            end
            cdl_pkg::REQ_DELETE: begin
              if (count_q == '0) begin
                status_d = cdl_pkg::STAT_NOT_FOUND;
                state_d  = cdl_pkg::ST_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                state_d = cdl_pkg::ST_DEL_CHK;
              end
            end
            cdl_pkg::REQ_REVERSE: begin
              status_d = cdl_pkg::STAT_OK;
              if (count_q < CntW'(2)) begin
                state_d = cdl_pkg::ST_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                state_d = cdl_pkg::ST_REV_STEP;
              end
            end
            cdl_pkg::REQ_TRAVERSE: begin
              if (count_q == '0) begin
                status_d = cdl_pkg::STAT_EMPTY;
                state_d  = cdl_pkg::ST_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                state_d = cdl_pkg::ST_TRV_OUT;
              end
            end
            default: begin
              status_d = cdl_pkg::STAT_OK;
              state_d  = cdl_pkg::ST_RESP;
            end
          endcase
        end
      end

      cdl_pkg::ST_INS_LINK: begin
        // splice the new node between tail and head
        nxt_we    = 1'b1;
        nxt_waddr = tail_q;
        nxt_wdata = slot_q;
        prv_we    = 1'b1;
        prv_waddr = head_q;
        prv_wdata = slot_q;
        if (at_front_q) head_d = slot_q;
        else            tail_d = slot_q;
        state_d   = cdl_pkg::ST_RESP;
      end

      cdl_pkg::ST_DEL_CHK: begin
        // read data belongs to node cur_q
        if (val_rdata_q == value_q) begin
          if (count_q == CntW'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            nxt_we    = 1'b1;
            nxt_waddr = prv_rdata_q;
            nxt_wdata = nxt_rdata_q;
            prv_we    = 1'b1;
            prv_waddr = nxt_rdata_q;
            prv_wdata = prv_rdata_q;
            if (cur_q == head_q) head_d = nxt_rdata_q;
            if (cur_q == tail_q) tail_d = prv_rdata_q;
          end
          used_d[cur_q] = 1'b0;
          count_d  = count_q - CntW'(1);
          status_d = cdl_pkg::STAT_OK;
          state_d  = cdl_pkg::ST_RESP;
        end else if (walk_last) begin
          status_d = cdl_pkg::STAT_NOT_FOUND;
          state_d  = cdl_pkg::ST_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = nxt_rdata_q;
          cur_d   = nxt_rdata_q;
          k_d     = k_q + CntW'(1);
        end
      end

      cdl_pkg::ST_REV_STEP: begin
        // swap the links of node cur_q while fetching the next one
        nxt_we    = 1'b1;
        nxt_waddr = cur_q;
        nxt_wdata = prv_rdata_q;
        prv_we    = 1'b1;
        prv_waddr = cur_q;
        prv_wdata = nxt_rdata_q;
        k_d       = k_q + CntW'(1);
        if (walk_last) begin
          head_d  = tail_q;
          tail_d  = head_q;
          state_d = cdl_pkg::ST_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = nxt_rdata_q;
          cur_d   = nxt_rdata_q;
        end
      end

      cdl_pkg::ST_TRV_OUT: begin
        // read data is held while the output register is blocked
        if (can_load) begin
          out_load     = 1'b1;
          out_value_d  = val_rdata_q;
          out_status_d = cdl_pkg::STAT_OK;
          out_elem_d   = 1'b1;
          out_last_d   = walk_last;
          k_d          = k_q + CntW'(1);
          if (walk_last) begin
            state_d = cdl_pkg::ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = nxt_rdata_q;
          end
        end
      end

      cdl_pkg::ST_RESP: begin
        if (can_load) begin
          out_load = 1'b1;
          state_d  = cdl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cdl_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdl_pkg::ST_IDLE;
      used_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    at_front_q <= at_front_d;
    slot_q     <= slot_d;
    cur_q      <= cur_d;
    k_q        <= k_d;
    status_q   <= status_d;
    if (out_load) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_elem_q   <= out_elem_d;
      out_last_q   <= out_last_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.out_value  = out_value_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.is_element = out_elem_q;
  assign rsp_o.last       = out_last_q;

endmodule

/* rtl/cdl_checker.sv */
// port-level checks on the response channel of the circular list engine
// depends on cdl_pkg and assert_macros.svh; bound to circular_double_list_engine
`include "assert_macros.svh"

module cdl_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               rsp_valid_i,
  input logic                               rsp_ready_i,
  input logic signed [cdl_pkg::ValueW-1:0]  rsp_value_i,
  input logic [cdl_pkg::StatusW-1:0]        rsp_status_i,
  input logic                               rsp_elem_i,
  input logic                               rsp_last_i
);

  // a pending result stays offered
  `CDL_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result withdrawn before transaction")

  // a pending result keeps its payload
  `CDL_ASSERT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> $stable(rsp_value_i) && $stable(rsp_status_i) && $stable(rsp_elem_i) && $stable(rsp_last_i), "result payload changed while stalled")

  // traversed elements always carry status ok
  `CDL_ASSERT_NEVER(a_elem_ok, clk_i, rst_ni, rsp_valid_i && rsp_elem_i && (rsp_status_i != cdl_pkg::STAT_OK), "element with non-ok status")

  // a status result is single, final and carries zero
  `CDL_ASSERT(a_status_last, clk_i, rst_ni, rsp_valid_i && !rsp_elem_i |-> rsp_last_i && (rsp_value_i == '0), "status result not last or value non-zero")

endmodule

bind circular_double_list_engine cdl_checker u_cdl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_value_i  (rsp_o.out_value),
  .rsp_status_i (rsp_o.status),
  .rsp_elem_i   (rsp_o.is_element),
  .rsp_last_i   (rsp_o.last)
);
